// ----- rtl/rte_pkg.sv -----
// Package for the relation table engine: entry and query types, command and
// status codes, and the default table depth. No dependencies.
package rte_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int OTYPE_W    = 15;
    localparam int FIDX_W     = 6;
    localparam int FCNT_W     = 7;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_FIND   = 3'd2;
    localparam logic [2:0] CMD_NEXT   = 3'd3;
    localparam logic [2:0] CMD_PREV   = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [15:0] rel_type;
        logic [15:0] rel_id;
        logic [15:0] unit_type;
        logic [15:0] unit_id;
    } rte_entry_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] rel_type;
        logic [15:0] rel_id;
        logic [15:0] unit_type;
        logic [15:0] unit_id;
        logic [7:0]  position;
    } rte_query_t;

    typedef struct packed {
        logic append;
        logic remove;
        logic eval;
    } rte_cell_ctrl_t;

endpackage

// ----- rtl/rte_cell.sv -----
// One table cell: holds a single entry, takes its upper neighbor's entry on a
// delete, and registers its own match flag for a find or search.
// Depends on rte_pkg.
module rte_cell import rte_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  logic                               aclk,
    input  rte_cell_ctrl_t                     ctrl,
    input  rte_query_t                         query,
    input  logic [OTYPE_W-1:0]                 outgoing_type,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
    input  rte_entry_t                         next_entry,
    output rte_entry_t                         entry,
    output logic                               hit
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;

    rte_entry_t entry_reg;
    logic       hit_reg;
    logic       hit_next;

    logic signed [CMP_W-1:0] idx_s;
    logic signed [CMP_W-1:0] pos_s;
    logic signed [16:0]      stored_s;
    logic signed [16:0]      mag_s;
    logic signed [16:0]      query_s;
    logic signed [16:0]      in_type_s;
    logic                    valid;
    logic                    tuple_eq;

    assign idx_s     = CMP_W'(CELL_INDEX);
    assign pos_s     = CMP_W'($signed(query.position));
    assign valid     = CNT_W'(CELL_INDEX) < count;
    assign stored_s  = 17'($signed(entry_reg.rel_type));
    assign mag_s     = stored_s[16] ? -stored_s : stored_s;
    assign query_s   = 17'($signed(query.rel_type));
    assign in_type_s = -$signed({2'b00, outgoing_type});
    assign tuple_eq  = (query_s == mag_s) && (query.rel_id == entry_reg.rel_id) &&
                       (query.unit_type == entry_reg.unit_type) &&
                       (query.unit_id == entry_reg.unit_id);

    always_comb begin
        hit_next = 1'b0;
        unique case (query.cmd)
            CMD_FIND: hit_next = valid && tuple_eq;
            CMD_NEXT: hit_next = valid && (idx_s > pos_s) &&
                                 (entry_reg.rel_type == {1'b0, outgoing_type});
            CMD_PREV: hit_next = valid && (idx_s < pos_s) && (stored_s == in_type_s);
            default:  hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.append && (count == CNT_W'(CELL_INDEX))) begin
            entry_reg <= '{rel_type:  query.rel_type,
                           rel_id:    query.rel_id,
                           unit_type: query.unit_type,
                           unit_id:   query.unit_id};
        end else if (ctrl.remove && (idx_s >= pos_s)) begin
            entry_reg <= next_entry;
        end
        if (ctrl.eval) begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// ----- rtl/relation_table_engine.sv -----
// Append, delete and unused commands go from input transaction to result
// through the EXEC and DONE states; find and searches add a SCAN state in which
// a sequencer walks the registered cell match flags cell by cell, up to
// TABLE_DEPTH cells. A new transaction is taken only after the last result.
// Reset (aresetn low, synchronous) empties the table, sets outgoing_type to 1
// and drops any pending result.
module relation_table_engine import rte_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OTYPE_W-1:0]    cfg_data,       // outgoing_type
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cmd[2:0], rel_type[18:3], rel_id[34:19], unit_type[50:35],
    // unit_id[66:51], position[74:67], zero[79:75]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // found[0], found_index[6:1], entry_count[13:7], status[15:14]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    rte_query_t            query_reg;
    logic [OTYPE_W-1:0]    otype_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      index_reg, index_next;
    logic [1:0]            status_reg, status_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    rte_cell_ctrl_t        ctrl;
    rte_entry_t            entry_w [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_w;

    logic                  s_fire;
    logic                  out_free;
    logic                  hit_sel;
    logic                  scan_end;
    logic signed [CMP_W-1:0] pos_s;
    logic signed [CMP_W-1:0] cnt_s;
    logic [31:0]           index_wide;
    logic [31:0]           count_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign pos_s     = CMP_W'($signed(query_reg.position));
    assign cnt_s     = CMP_W'(count_reg);
    assign hit_sel   = hit_w[scan_reg];
    assign scan_end  = (query_reg.cmd == CMD_PREV) ? (scan_reg == '0)
                                                   : (scan_reg == IDX_W'(TABLE_DEPTH - 1));
    assign index_wide = 32'(index_reg);
    assign count_wide = 32'(count_reg);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            rte_entry_t nb;
            if (gi == TABLE_DEPTH - 1) begin : g_last
                assign nb = entry_w[gi];
            end else begin : g_mid
                assign nb = entry_w[gi+1];
            end
            rte_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .CELL_INDEX  (gi)
            ) u_cell (
                .aclk          (aclk),
                .ctrl          (ctrl),
                .query         (query_reg),
                .outgoing_type (otype_reg),
                .count         (count_reg),
                .next_entry    (nb),
                .entry         (entry_w[gi]),
                .hit           (hit_w[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        found_next    = found_reg;
        index_next    = index_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ctrl          = '{append: 1'b0, remove: 1'b0, eval: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                found_next  = 1'b0;
                index_next  = '0;
                status_next = STATUS_OK;
                state_next  = ST_DONE;
                unique case (query_reg.cmd)
                    CMD_APPEND: begin
                        if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                            status_next = STATUS_FULL;
                        end else begin
                            ctrl.append = 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        if (pos_s < 0 || pos_s >= cnt_s) begin
                            status_next = STATUS_BAD_INDEX;
                        end else begin
                            ctrl.remove = 1'b1;
                            count_next  = count_reg - 1'b1;
                        end
                    end
                    CMD_FIND, CMD_NEXT, CMD_PREV: begin
                        ctrl.eval  = 1'b1;
                        state_next = ST_SCAN;
                        scan_next  = (query_reg.cmd == CMD_PREV) ?
                                     IDX_W'(TABLE_DEPTH - 1) : '0;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (hit_sel) begin
                    found_next = 1'b1;
                    index_next = scan_reg;
                    state_next = ST_DONE;
                end else if (scan_end) begin
                    state_next = ST_DONE;
                end else if (query_reg.cmd == CMD_PREV) begin
                    scan_next = scan_reg - 1'b1;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {status_reg, count_wide[FCNT_W-1:0],
                                     index_wide[FIDX_W-1:0], found_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            otype_reg    <= OTYPE_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                otype_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            query_reg <= '{cmd:       s_tdata[2:0],
                           rel_type:  s_tdata[18:3],
                           rel_id:    s_tdata[34:19],
                           unit_type: s_tdata[50:35],
                           unit_id:   s_tdata[66:51],
                           position:  s_tdata[74:67]};
        end
        scan_reg    <= scan_next;
        found_reg   <= found_next;
        index_reg   <= index_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds the table depth");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not start execution");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.remove |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not decrement the entry count");

    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.append |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not increment the entry count");

    a_scan_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && hit_sel) |=> (state_reg == ST_DONE && found_reg))
        else $error("scan hit was not reported as found");

endmodule
